// ----- sv/look_at_view_matrix_defines.svh -----
// Assertion macros used by the checker of this block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Same-cycle implication.
`define LAVM_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("look_at_view_matrix check failed");

// Next-cycle implication.
`define LAVM_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("look_at_view_matrix check failed");

`endif

// ----- sv/lavm_pkg.sv -----
`timescale 1ns / 1ps

package lavm_pkg;

    // Normalizer scales the largest magnitude into [2^SCALE_LO_BIT, 2^SCALE_HI_BIT).
    localparam int SCALE_LO_BIT = 29;
    localparam int SCALE_HI_BIT = 30;
    // Width of normalizer results and multiplier operands.
    localparam int VEC_BITS     = 32;
    // Width of vectors handed to the normalizer.
    localparam int WIDE_BITS    = 64;
    // Origin components are split at this bit for the dot products.
    localparam int SPLIT_BITS   = 24;
    localparam int GROUPS       = 4;

    typedef enum logic [2:0] {
        N_IDLE,
        N_MAG,
        N_SCALE,
        N_SQ,
        N_SQRT,
        N_DIV
    } t_nrm_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_F,
        B_S,
        B_CROSS,
        B_R,
        B_U,
        B_DOT,
        B_EMIT
    } t_back_state;

    typedef struct packed {
        logic start;
        logic scale_only;
    } t_nrm_req;

    typedef struct packed {
        logic done;
        logic ok;
    } t_nrm_rsp;

endpackage

// ----- sv/lavm_if.sv -----
`timescale 1ns / 1ps

interface lavm_in_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] origin_x;
    logic signed [WORD_BITS-1:0] origin_y;
    logic signed [WORD_BITS-1:0] origin_z;
    logic signed [WORD_BITS-1:0] dir_x;
    logic signed [WORD_BITS-1:0] dir_y;
    logic signed [WORD_BITS-1:0] dir_z;
    logic signed [WORD_BITS-1:0] up_x;
    logic signed [WORD_BITS-1:0] up_y;
    logic signed [WORD_BITS-1:0] up_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, up_x, up_y, up_z,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, up_x, up_y, up_z,
        output ready
    );
endinterface

interface lavm_out_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  group_index;
    logic signed [WORD_BITS-1:0] first_value;
    logic signed [WORD_BITS-1:0] second_value;
    logic signed [WORD_BITS-1:0] third_value;
    logic signed [WORD_BITS-1:0] fourth_value;
    logic                        last;
    logic                        degenerate;

    modport source (
        output valid, group_index, first_value, second_value, third_value, fourth_value,
               last, degenerate,
        input  ready
    );
    modport sink (
        input  valid, group_index, first_value, second_value, third_value, fourth_value,
               last, degenerate,
        output ready
    );
endinterface

// ----- sv/lavm_front.sv -----
`timescale 1ns / 1ps

module lavm_front #(
    parameter int WORD_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lavm_in_if.sink                i_in,
    output logic                   o_q_valid,
    output logic [9*WORD_BITS:0]   o_q_data,
    input  logic                   i_q_pop
);
    localparam int ITEM_BITS = 9 * WORD_BITS + 1;

    logic [ITEM_BITS-1:0] r_mem [2];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic                 w_push;
    logic                 w_zero;
    logic [ITEM_BITS-1:0] w_item;

    // classify: flag a zero direction so the back end can skip its work
    assign w_zero = (i_in.dir_x == '0) && (i_in.dir_y == '0) && (i_in.dir_z == '0);
    assign w_item = {w_zero, i_in.up_z, i_in.up_y, i_in.up_x, i_in.dir_z, i_in.dir_y,
                     i_in.dir_x, i_in.origin_z, i_in.origin_y, i_in.origin_x};

    assign i_in.ready = (r_cnt != 2'd2);
    assign w_push     = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ----- sv/lavm_norm.sv -----
`timescale 1ns / 1ps

module lavm_norm #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lavm_pkg::t_nrm_req   i_req,
    input  logic [2:0][63:0]     i_vec,
    output lavm_pkg::t_nrm_rsp   o_rsp,
    output logic [2:0][31:0]     o_q
);
    localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

    lavm_pkg::t_nrm_state r_st, n_st;
    logic [2:0]          r_neg, n_neg;
    logic [2:0][63:0]    r_m, n_m;
    logic [63:0]         r_mx, n_mx;
    logic                r_so, n_so;
    logic [59:0]         r_prod, n_prod;
    logic [63:0]         r_sum, n_sum;
    logic [63:0]         r_rem, n_rem;
    logic [63:0]         r_res, n_res;
    logic [63:0]         r_bit, n_bit;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [1:0]          r_idx, n_idx;
    logic [31:0]         r_qa, n_qa;
    logic [31:0]         r_n, n_n;
    logic [2:0][31:0]    r_q, n_q;
    logic                r_done, n_done;
    logic                r_ok, n_ok;

    logic [63:0] w_try;
    logic [63:0] w_res;
    logic [63:0] w_den;
    logic [31:0] w_qa;

    assign o_rsp.done = r_done;
    assign o_rsp.ok   = r_ok;
    assign o_q        = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= lavm_pkg::N_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_m    <= n_m;
        r_mx   <= n_mx;
        r_so   <= n_so;
        r_prod <= n_prod;
        r_sum  <= n_sum;
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_qa   <= n_qa;
        r_n    <= n_n;
        r_q    <= n_q;
        r_ok   <= n_ok;
    end

    always_comb begin
        n_st   = r_st;
        n_neg  = r_neg;
        n_m    = r_m;
        n_mx   = r_mx;
        n_so   = r_so;
        n_prod = r_prod;
        n_sum  = r_sum;
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        n_qa   = r_qa;
        n_n    = r_n;
        n_q    = r_q;
        n_done = 1'b0;
        n_ok   = r_ok;
        w_try  = r_res + r_bit;
        w_res  = r_res >> 1;
        w_den  = {31'b0, r_n, 1'b0} << r_cnt;
        w_qa   = r_qa;
        unique case (r_st)
            lavm_pkg::N_IDLE: begin
                if (i_req.start) begin
                    for (int i = 0; i < 3; i++) begin
                        n_neg[i] = i_vec[i][63];
                        n_m[i]   = i_vec[i][63] ? (64'd0 - i_vec[i]) : i_vec[i];
                    end
                    n_so = i_req.scale_only;
                    n_st = lavm_pkg::N_MAG;
                end
            end
            lavm_pkg::N_MAG: begin
                n_mx = r_m[0];
                if (r_m[1] > n_mx) n_mx = r_m[1];
                if (r_m[2] > n_mx) n_mx = r_m[2];
                if (n_mx == '0) begin
                    // all zero: no direction to form
                    n_done = 1'b1;
                    n_ok   = 1'b0;
                    n_st   = lavm_pkg::N_IDLE;
                end else begin
                    n_st = lavm_pkg::N_SCALE;
                end
            end
            lavm_pkg::N_SCALE: begin
                if (r_mx[63:lavm_pkg::SCALE_HI_BIT] != '0) begin
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] >> 1;
                    n_mx = r_mx >> 1;
                end else if (!r_mx[lavm_pkg::SCALE_LO_BIT]) begin
                    for (int i = 0; i < 3; i++) n_m[i] = r_m[i] << 1;
                    n_mx = r_mx << 1;
                end else if (r_so) begin
                    for (int i = 0; i < 3; i++) begin
                        n_q[i] = r_neg[i] ? (32'd0 - r_m[i][31:0]) : r_m[i][31:0];
                    end
                    n_done = 1'b1;
                    n_ok   = 1'b1;
                    n_st   = lavm_pkg::N_IDLE;
                end else begin
                    n_cnt = '0;
                    n_sum = '0;
                    n_st  = lavm_pkg::N_SQ;
                end
            end
            lavm_pkg::N_SQ: begin
                // square one component, accumulate the previous square
                if (r_cnt < CNT_BITS'(3)) begin
                    n_prod = r_m[r_cnt[1:0]][29:0] * r_m[r_cnt[1:0]][29:0];
                end
                if (r_cnt != '0) begin
                    n_sum = r_sum + {4'b0, r_prod};
                end
                if (r_cnt == CNT_BITS'(3)) begin
                    n_rem = r_sum + {4'b0, r_prod};
                    n_res = '0;
                    n_bit = 64'd1 << 60;
                    n_st  = lavm_pkg::N_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            lavm_pkg::N_SQRT: begin
                if (r_rem >= w_try) begin
                    n_rem = r_rem - w_try;
                    w_res = (r_res >> 1) + r_bit;
                end
                n_res = w_res;
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_n   = w_res[31:0];
                    n_rem = (r_m[0] << (FRAC_BITS + 1)) + {32'b0, w_res[31:0]};
                    n_cnt = CNT_BITS'(FRAC_BITS);
                    n_idx = 2'd0;
                    n_qa  = '0;
                    n_st  = lavm_pkg::N_DIV;
                end
            end
            lavm_pkg::N_DIV: begin
                // one quotient bit a cycle, rounded quotient m*2^F/n
                if (r_rem >= w_den) begin
                    n_rem = r_rem - w_den;
                    w_qa  = r_qa | (32'd1 << r_cnt);
                end
                n_qa = w_qa;
                if (r_cnt == '0) begin
                    n_q[r_idx] = r_neg[r_idx] ? (32'd0 - w_qa) : w_qa;
                    if (r_idx == 2'd2) begin
                        n_done = 1'b1;
                        n_ok   = 1'b1;
                        n_st   = lavm_pkg::N_IDLE;
                    end else begin
                        n_idx = r_idx + 2'd1;
                        n_rem = (r_m[r_idx + 2'd1] << (FRAC_BITS + 1)) + {32'b0, r_n};
                        n_cnt = CNT_BITS'(FRAC_BITS);
                        n_qa  = '0;
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_st = lavm_pkg::N_IDLE;
            end
        endcase
    end
endmodule

// ----- sv/lavm_back.sv -----
`timescale 1ns / 1ps

module lavm_back #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  logic [9*WORD_BITS:0] i_q_data,
    output logic                 o_q_pop,
    output lavm_pkg::t_nrm_req   o_nrm_req,
    output logic [2:0][63:0]     o_nrm_vec,
    input  lavm_pkg::t_nrm_rsp   i_nrm_rsp,
    input  logic [2:0][31:0]     i_nrm_q,
    lavm_out_if.source           o_out
);
    localparam int ACC_BITS = (WORD_BITS + 34 > 66) ? WORD_BITS + 34 : 66;
    localparam logic signed [ACC_BITS-1:0] ONE_FX = ACC_BITS'(1) <<< FRAC_BITS;
    localparam logic signed [ACC_BITS-1:0] HALF   = ACC_BITS'(1) <<< (FRAC_BITS - 1);

    lavm_pkg::t_back_state r_st, n_st;
    lavm_pkg::t_nrm_req    r_nreq, n_nreq;
    logic [2:0][63:0]          r_nvec, n_nvec;
    logic [2:0][WORD_BITS-1:0] r_o, n_o;
    logic [2:0][WORD_BITS-1:0] r_up, n_up;
    logic [2:0][31:0]          r_f, n_f;
    logic [2:0][31:0]          r_s, n_s;
    logic [2:0][31:0]          r_r, n_r;
    logic [2:0][31:0]          r_u, n_u;
    logic [2:0][WORD_BITS-1:0] r_t, n_t;
    logic                      r_deg, n_deg;
    logic [1:0]                r_j, n_j;
    logic [2:0]                r_k, n_k;
    logic [1:0]                r_ph, n_ph;
    logic signed [ACC_BITS-1:0] r_acc, n_acc;
    logic signed [63:0]        r_prod, n_prod;
    logic                      r_psub, n_psub;
    logic                      r_psh, n_psh;
    logic [1:0]                r_grp, n_grp;
    logic                      r_ov, n_ov;
    logic [1:0]                r_og, n_og;
    logic [3:0][WORD_BITS-1:0] r_oval, n_oval;
    logic                      r_olast, n_olast;
    logic                      r_odeg, n_odeg;

    logic [1:0]                 w_p, w_q, w_i;
    logic signed [31:0]         w_a, w_b;
    logic                       w_sub, w_sh;
    logic [2:0]                 w_klast;
    logic signed [ACC_BITS-1:0] w_pext;
    logic signed [ACC_BITS-1:0] w_rnd;
    logic signed [63:0]         w_ow;
    logic                       w_ld;

    function automatic logic [WORD_BITS-1:0] f_sat(input logic signed [ACC_BITS-1:0] x);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        logic [WORD_BITS-1:0]       y;
        hi = $signed({{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
        lo = ~hi;
        if (x > hi) begin
            y = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (x < lo) begin
            y = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            y = x[WORD_BITS-1:0];
        end
        return y;
    endfunction

    function automatic logic signed [ACC_BITS-1:0] f_sx(input logic [31:0] x);
        return ACC_BITS'($signed(x));
    endfunction

    assign o_nrm_req         = r_nreq;
    assign o_nrm_vec         = r_nvec;
    assign o_q_pop           = i_q_valid && (r_st == lavm_pkg::B_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.group_index = r_og;
    assign o_out.first_value = r_oval[0];
    assign o_out.second_value = r_oval[1];
    assign o_out.third_value = r_oval[2];
    assign o_out.fourth_value = r_oval[3];
    assign o_out.last        = r_olast;
    assign o_out.degenerate  = r_odeg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= lavm_pkg::B_IDLE;
            r_nreq <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_nreq <= n_nreq;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nvec  <= n_nvec;
        r_o     <= n_o;
        r_up    <= n_up;
        r_f     <= n_f;
        r_s     <= n_s;
        r_r     <= n_r;
        r_u     <= n_u;
        r_t     <= n_t;
        r_deg   <= n_deg;
        r_j     <= n_j;
        r_k     <= n_k;
        r_ph    <= n_ph;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_psub  <= n_psub;
        r_psh   <= n_psh;
        r_grp   <= n_grp;
        r_og    <= n_og;
        r_oval  <= n_oval;
        r_olast <= n_olast;
        r_odeg  <= n_odeg;
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_j)
            2'd0: begin
                w_p = 2'd1;
                w_q = 2'd2;
            end
            2'd1: begin
                w_p = 2'd2;
                w_q = 2'd0;
            end
            default: begin
                w_p = 2'd0;
                w_q = 2'd1;
            end
        endcase
        w_i   = r_k[2:1];
        w_ow  = 64'($signed(r_o[w_i])) >>> lavm_pkg::SPLIT_BITS;
        w_sub = 1'b0;
        w_sh  = 1'b0;
        w_a   = '0;
        w_b   = '0;
        w_klast = 3'd1;
        priority case (r_st)
            lavm_pkg::B_CROSS: begin
                w_a   = (r_k == 3'd0) ? r_f[w_p] : r_f[w_q];
                w_b   = (r_k == 3'd0) ? r_s[w_q] : r_s[w_p];
                w_sub = (r_k != 3'd0);
            end
            lavm_pkg::B_U: begin
                w_a   = (r_k == 3'd0) ? r_r[w_p] : r_r[w_q];
                w_b   = (r_k == 3'd0) ? r_f[w_q] : r_f[w_p];
                w_sub = (r_k != 3'd0);
            end
            lavm_pkg::B_DOT: begin
                w_klast = 3'd5;
                unique case (r_j)
                    2'd0:    w_a = r_r[w_i];
                    2'd1:    w_a = r_u[w_i];
                    default: w_a = r_f[w_i];
                endcase
                // low half unsigned, high half signed and shifted up
                if (r_k[0]) begin
                    w_b  = w_ow[31:0];
                    w_sh = 1'b1;
                end else begin
                    w_b = {{(32-lavm_pkg::SPLIT_BITS){1'b0}},
                           r_o[w_i][lavm_pkg::SPLIT_BITS-1:0]};
                end
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    always_comb begin
        n_st    = r_st;
        n_nreq  = '0;
        n_nvec  = r_nvec;
        n_o     = r_o;
        n_up    = r_up;
        n_f     = r_f;
        n_s     = r_s;
        n_r     = r_r;
        n_u     = r_u;
        n_t     = r_t;
        n_deg   = r_deg;
        n_j     = r_j;
        n_k     = r_k;
        n_ph    = r_ph;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_psub  = r_psub;
        n_psh   = r_psh;
        n_grp   = r_grp;
        n_og    = r_og;
        n_oval  = r_oval;
        n_olast = r_olast;
        n_odeg  = r_odeg;
        n_ov    = (r_ov && o_out.ready) ? 1'b0 : r_ov;
        w_ld    = !r_ov || o_out.ready;
        w_pext  = ACC_BITS'(r_prod);
        if (r_psh) begin
            w_pext = w_pext <<< lavm_pkg::SPLIT_BITS;
        end
        w_rnd = (r_acc + HALF) >>> FRAC_BITS;

        unique case (r_st)
            lavm_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    n_deg = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        n_o[i]    = i_q_data[i*WORD_BITS +: WORD_BITS];
                        n_up[i]   = i_q_data[(6+i)*WORD_BITS +: WORD_BITS];
                        n_nvec[i] = 64'($signed(i_q_data[(3+i)*WORD_BITS +: WORD_BITS]));
                    end
                    if (i_q_data[9*WORD_BITS]) begin
                        n_deg = 1'b1;
                        n_grp = 2'd0;
                        n_st  = lavm_pkg::B_EMIT;
                    end else begin
                        n_nreq.start = 1'b1;
                        n_st         = lavm_pkg::B_F;
                    end
                end
            end
            lavm_pkg::B_F: begin
                if (i_nrm_rsp.done) begin
                    if (!i_nrm_rsp.ok) begin
                        n_deg = 1'b1;
                        n_grp = 2'd0;
                        n_st  = lavm_pkg::B_EMIT;
                    end else begin
                        n_f = i_nrm_q;
                        for (int i = 0; i < 3; i++) n_nvec[i] = 64'($signed(r_up[i]));
                        n_nreq.start      = 1'b1;
                        n_nreq.scale_only = 1'b1;
                        n_st              = lavm_pkg::B_S;
                    end
                end
            end
            lavm_pkg::B_S, lavm_pkg::B_R: begin
                if (i_nrm_rsp.done) begin
                    if (!i_nrm_rsp.ok) begin
                        n_deg = 1'b1;
                        n_grp = 2'd0;
                        n_st  = lavm_pkg::B_EMIT;
                    end else begin
                        if (r_st == lavm_pkg::B_S) begin
                            n_s  = i_nrm_q;
                            n_st = lavm_pkg::B_CROSS;
                        end else begin
                            n_r  = i_nrm_q;
                            n_st = lavm_pkg::B_U;
                        end
                        n_j   = 2'd0;
                        n_k   = 3'd0;
                        n_ph  = 2'd0;
                        n_acc = '0;
                    end
                end
            end
            lavm_pkg::B_CROSS, lavm_pkg::B_U, lavm_pkg::B_DOT: begin
                unique case (r_ph)
                    2'd0: begin
                        n_prod = w_a * w_b;
                        n_psub = w_sub;
                        n_psh  = w_sh;
                        n_ph   = 2'd1;
                    end
                    2'd1: begin
                        n_acc = r_psub ? (r_acc - w_pext) : (r_acc + w_pext);
                        if (r_k == w_klast) begin
                            n_ph = 2'd2;
                        end else begin
                            n_k  = r_k + 3'd1;
                            n_ph = 2'd0;
                        end
                    end
                    default: begin
                        // store the finished sum, then move to the next component
                        if (r_st == lavm_pkg::B_CROSS) begin
                            n_nvec[r_j] = r_acc[63:0];
                        end else if (r_st == lavm_pkg::B_U) begin
                            n_u[r_j] = w_rnd[31:0];
                        end else begin
                            n_t[r_j] = f_sat((r_j == 2'd2) ? w_rnd : -w_rnd);
                        end
                        n_acc = '0;
                        n_k   = 3'd0;
                        n_ph  = 2'd0;
                        if (r_j == 2'd2) begin
                            n_j = 2'd0;
                            if (r_st == lavm_pkg::B_CROSS) begin
                                n_nreq.start = 1'b1;
                                n_st         = lavm_pkg::B_R;
                            end else if (r_st == lavm_pkg::B_U) begin
                                n_st = lavm_pkg::B_DOT;
                            end else begin
                                n_grp = 2'd0;
                                n_st  = lavm_pkg::B_EMIT;
                            end
                        end else begin
                            n_j = r_j + 2'd1;
                        end
                    end
                endcase
            end
            lavm_pkg::B_EMIT: begin
                if (w_ld) begin
                    n_ov    = 1'b1;
                    n_og    = r_grp;
                    n_olast = (r_grp == 2'd3);
                    n_odeg  = r_deg;
                    if (r_deg) begin
                        n_oval = '0;
                    end else if (r_grp == 2'd3) begin
                        n_oval[0] = r_t[0];
                        n_oval[1] = r_t[1];
                        n_oval[2] = r_t[2];
                        n_oval[3] = f_sat(ONE_FX);
                    end else begin
                        n_oval[0] = f_sat(f_sx(r_r[r_grp]));
                        n_oval[1] = f_sat(f_sx(r_u[r_grp]));
                        n_oval[2] = f_sat(-f_sx(r_f[r_grp]));
                        n_oval[3] = '0;
                    end
                    if (r_grp == 2'd3) begin
                        n_st = lavm_pkg::B_IDLE;
                    end else begin
                        n_grp = r_grp + 2'd1;
                    end
                end
            end
            default: begin
                n_st = lavm_pkg::B_IDLE;
            end
        endcase
    end
endmodule

// ----- sv/look_at_view_matrix.sv -----
// Look-at view matrix: one input item gives four result items (matrix groups 0..3).
// The back end works on one item at a time and takes the next one from the queue once
// group 3 is in the output register; the shared normalizer's square root and divider
// produce one bit a cycle, and a zero direction skips the normalizer altogether.
// Reset: synchronous, active low; clears the queue, sequencers and output valid.
`timescale 1ns / 1ps

module look_at_view_matrix #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lavm_in_if.sink     i_in,
    lavm_out_if.source  o_out
);
    localparam int ITEM_BITS = 9 * WORD_BITS + 1;

    // Front: two-entry item queue; flags a zero direction on entry.
    logic                 w_q_valid;
    logic [ITEM_BITS-1:0] w_q_data;
    logic                 w_q_pop;

    // Back <-> normalizer: shared scale / square root / divide unit.
    lavm_pkg::t_nrm_req   w_nrm_req;
    lavm_pkg::t_nrm_rsp   w_nrm_rsp;
    logic [2:0][63:0]     w_nrm_vec;
    logic [2:0][31:0]     w_nrm_q;

    lavm_front #(
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_data  (w_q_data),
        .i_q_pop   (w_q_pop)
    );

    // Normalizer serves f = normalize(dir), the scaling of up, and r = normalize(f x up).
    lavm_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_nrm_req),
        .i_vec   (w_nrm_vec),
        .o_rsp   (w_nrm_rsp),
        .o_q     (w_nrm_q)
    );

    // Back: sequences the normalizer and a shared 32x32 multiply-accumulate for the
    // cross products, u = r x f and the origin dot products, then emits four groups
    // through an output register so it can take the next queued item while group 3 waits.
    lavm_back #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_nrm_req (w_nrm_req),
        .o_nrm_vec (w_nrm_vec),
        .i_nrm_rsp (w_nrm_rsp),
        .i_nrm_q   (w_nrm_q),
        .o_out     (o_out)
    );
endmodule

// ----- sv/lavm_checker.sv -----
`timescale 1ns / 1ps
`include "look_at_view_matrix_defines.svh"

module lavm_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic [1:0]           i_group_index,
    input logic [WORD_BITS-1:0] i_first_value,
    input logic [WORD_BITS-1:0] i_second_value,
    input logic [WORD_BITS-1:0] i_third_value,
    input logic [WORD_BITS-1:0] i_fourth_value,
    input logic                 i_last,
    input logic                 i_degenerate
);
    // hold a stalled item
    `LAVM_AST_NXT(a_hold_stalled, i_valid && !i_ready, i_valid)
    // last marks group 3 only
    `LAVM_AST_IMP(a_last_group, i_valid, i_last == (i_group_index == 2'd3))
    // a degenerate basis gives an all-zero matrix
    `LAVM_AST_IMP(a_deg_zero, i_valid && i_degenerate, (i_first_value == '0) && (i_second_value == '0) && (i_third_value == '0) && (i_fourth_value == '0))
    // rotation rows end in zero
    `LAVM_AST_IMP(a_row_tail, i_valid && (i_group_index != 2'd3), i_fourth_value == '0)
    // groups of one matrix follow with no gap
    `LAVM_AST_NXT(a_group_seq, i_valid && i_ready && (i_group_index != 2'd3), i_valid && (i_group_index == 2'($past(i_group_index) + 2'd1)))
endmodule

bind look_at_view_matrix lavm_checker #(
    .WORD_BITS (WORD_BITS)
) u_lavm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_group_index  (o_out.group_index),
    .i_first_value  (o_out.first_value),
    .i_second_value (o_out.second_value),
    .i_third_value  (o_out.third_value),
    .i_fourth_value (o_out.fourth_value),
    .i_last         (o_out.last),
    .i_degenerate   (o_out.degenerate)
);
